FILE: rtl/dtw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtw_pkg: shared types and constants for the DTW similarity unit
// Opcodes, fixed field widths, arithmetic constants, state enums and the
// control bundle that travels along the systolic cell row.
// ----------------------------------------------------------------------------
package dtw_pkg;

  localparam int unsigned MAX_LEN_DEF = 64;

  localparam int unsigned OPC_W      = 2;
  localparam int unsigned VAL_W      = 15;
  localparam int unsigned DIST_OUT_W = 22;
  localparam int unsigned SIM_W      = 16;

  // pi in Q29, rounded
  localparam int unsigned PI_W = 31;
  localparam logic [PI_W-1:0] PI_Q29 = 31'd1686629713;

  // 8 * 2^29 scaling of the distance before the divide
  localparam int unsigned FRAC_SH = 32;
  // quotient bits produced by the divider; the top one means "clamp to 0"
  localparam int unsigned QUO_W  = 16;
  localparam int unsigned STEP_W = 4;

  localparam logic [DIST_OUT_W-1:0] DIST_MAX = 22'h3FFFFF;
  localparam logic [DIST_OUT_W-1:0] ONE_Q12  = 22'd4096;
  localparam logic [SIM_W-1:0]      ONE_Q15  = 16'd32768;

  typedef enum logic [OPC_W-1:0] {
    OP_LOAD_REF = 2'd0,
    OP_LOAD_QRY = 2'd1,
    OP_COMPUTE  = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_STREAM,
    TOP_DRAIN,
    TOP_DIV
  } top_state_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_MUL,
    DIV_INIT,
    DIV_RUN
  } div_state_e;

  // control that rides with each reference element down the row
  typedef struct packed {
    logic valid;
    logic first;  // row 0 of the cost matrix
    logic last;   // final reference element
  } cell_ctl_t;

endpackage

FILE: rtl/dtw_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtw_cell: one processing element of the systolic DTW row
// Holds one query element and its column's running sum. Each cycle it takes a
// reference element and the left neighbor's sum, forms cost plus min of three
// neighbors, and hands the element and the new sum to the next cell.
// ----------------------------------------------------------------------------
module dtw_cell #(
  parameter int unsigned SUM_W = 22
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 q_we_i,
  input  logic signed [dtw_pkg::VAL_W-1:0]     q_data_i,
  input  dtw_pkg::cell_ctl_t                   ctl_i,
  input  logic signed [dtw_pkg::VAL_W-1:0]     r_i,
  input  logic        [SUM_W-1:0]              sum_i,
  output dtw_pkg::cell_ctl_t                   ctl_o,
  output logic signed [dtw_pkg::VAL_W-1:0]     r_o,
  output logic        [SUM_W-1:0]              sum_o
);

  localparam logic [SUM_W-1:0] SUM_INF = {SUM_W{1'b1}};

  logic signed [dtw_pkg::VAL_W-1:0] q_q;
  logic        [SUM_W-1:0]          up_q;
  logic        [SUM_W-1:0]          diag_q;
  dtw_pkg::cell_ctl_t               ctl_q;
  logic signed [dtw_pkg::VAL_W-1:0] r_q;
  logic        [SUM_W-1:0]          sum_q;

  logic signed [dtw_pkg::VAL_W:0]   diff;
  logic        [dtw_pkg::VAL_W:0]   mag;
  logic        [dtw_pkg::VAL_W-1:0] cost;
  logic        [SUM_W-1:0]          up;
  logic        [SUM_W-1:0]          m_ab;
  logic        [SUM_W-1:0]          m_all;
  logic        [SUM_W-1:0]          sum_d;

  always_comb begin
    diff  = $signed({r_i[dtw_pkg::VAL_W-1], r_i}) - $signed({q_q[dtw_pkg::VAL_W-1], q_q});
    mag   = diff[dtw_pkg::VAL_W] ? $unsigned(-diff) : $unsigned(diff);
    cost  = mag[dtw_pkg::VAL_W-1:0];
    // no row above on the first reference element
    up    = ctl_i.first ? SUM_INF : up_q;
    m_ab  = (up < sum_i) ? up : sum_i;
    m_all = (m_ab < diag_q) ? m_ab : diag_q;
    sum_d = m_all + SUM_W'(cost);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
      sum_q <= SUM_INF;
    end else begin
      ctl_q <= ctl_i;
      // idle beats carry "no path" so the next cell's diagonal is correct
      sum_q <= ctl_i.valid ? sum_d : SUM_INF;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q    <= r_i;
    diag_q <= sum_i;
    if (ctl_i.valid) begin
      up_q <= sum_d;
    end
    if (q_we_i) begin
      q_q <= q_data_i;
    end
  end

  assign ctl_o = ctl_q;
  assign r_o   = r_q;
  assign sum_o = sum_q;

endmodule

FILE: rtl/dtw_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtw_div: similarity penalty divider
// Forms den = n * pi, then a restoring divide of (D << 32 + den/2) by den,
// one quotient bit per cycle, and returns 1.0 - quotient clamped at 0 (Q1.15).
// ----------------------------------------------------------------------------
module dtw_div #(
  parameter int unsigned SUM_W = 22,
  parameter int unsigned LEN_W = 7
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [SUM_W-1:0]                dist_i,
  input  logic [LEN_W-1:0]                len_i,
  output logic                            done_o,
  output logic [dtw_pkg::SIM_W-1:0]       sim_o
);

  localparam int unsigned DEN_W = LEN_W + dtw_pkg::PI_W;
  localparam int unsigned DIV_W = SUM_W + dtw_pkg::FRAC_SH + 2;

  dtw_pkg::div_state_e state_q, state_d;

  logic [SUM_W-1:0]                 dist_q;
  logic [LEN_W-1:0]                 len_q;
  logic [DEN_W-1:0]                 den_q;
  logic [DIV_W-1:0]                 rem_q;
  logic [DIV_W-1:0]                 dsh_q;
  logic [dtw_pkg::QUO_W-1:0]        quo_q;
  logic [dtw_pkg::STEP_W-1:0]       step_q;
  logic                             done_q;
  logic [dtw_pkg::SIM_W-1:0]        sim_q;

  logic                             ld_en, mul_en, init_en, run_en;
  logic                             ge;
  logic [dtw_pkg::QUO_W-1:0]        quo_nx;
  logic                             sat;
  logic                             finish;
  logic [dtw_pkg::SIM_W-1:0]        sim_d;

  assign ge     = (rem_q >= dsh_q);
  assign quo_nx = quo_q | (dtw_pkg::QUO_W'(ge) << step_q);
  assign sat    = quo_nx[dtw_pkg::QUO_W-1];
  assign finish = sat || (step_q == '0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dtw_pkg::DIV_IDLE: if (start_i) state_d = dtw_pkg::DIV_MUL;
      dtw_pkg::DIV_MUL:  state_d = dtw_pkg::DIV_INIT;
      dtw_pkg::DIV_INIT: state_d = dtw_pkg::DIV_RUN;
      dtw_pkg::DIV_RUN:  if (finish) state_d = dtw_pkg::DIV_IDLE;
      default:           state_d = dtw_pkg::DIV_IDLE;
    endcase
  end

  // outputs / enables
  always_comb begin
    ld_en   = 1'b0;
    mul_en  = 1'b0;
    init_en = 1'b0;
    run_en  = 1'b0;
    case (state_q)
      dtw_pkg::DIV_IDLE: ld_en   = start_i;
      dtw_pkg::DIV_MUL:  mul_en  = 1'b1;
      dtw_pkg::DIV_INIT: init_en = 1'b1;
      dtw_pkg::DIV_RUN:  run_en  = 1'b1;
      default:           ld_en   = 1'b0;
    endcase
    sim_d = sat ? '0 : dtw_pkg::SIM_W'(dtw_pkg::ONE_Q15 - quo_nx);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dtw_pkg::DIV_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= run_en && finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_en) begin
      dist_q <= dist_i;
      len_q  <= len_i;
    end
    if (mul_en) begin
      den_q <= DEN_W'(len_q) * DEN_W'(dtw_pkg::PI_Q29);
    end
    if (init_en) begin
      rem_q  <= (DIV_W'(dist_q) << dtw_pkg::FRAC_SH) + DIV_W'(den_q >> 1);
      dsh_q  <= DIV_W'(den_q) << (dtw_pkg::QUO_W - 1);
      quo_q  <= '0;
      step_q <= dtw_pkg::STEP_W'(dtw_pkg::QUO_W - 1);
    end
    if (run_en) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      dsh_q  <= dsh_q >> 1;
      quo_q  <= quo_nx;
      step_q <= step_q - dtw_pkg::STEP_W'(1);
      if (finish) begin
        sim_q <= sim_d;
      end
    end
  end

  assign done_o = done_q;
  assign sim_o  = sim_q;

endmodule

FILE: rtl/dtw_sequence_similarity_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtw_sequence_similarity_unit: DTW distance and similarity of two sequences
// Loads reference and query angle sequences, then runs the dynamic time
// warping recurrence on a systolic row of cells and reports the distance and
// a clamped similarity score.
// ----------------------------------------------------------------------------
// Usage: an item is taken when start is high and busy is low. Load beats
// (opcode 0 reference, 1 query) are taken one per cycle while busy is low
// and never raise busy; a load into a full store is dropped and reported as
// overflow_flag on the next compute. A compute beat (opcode 2) with either
// sequence empty returns its result on the next cycle without raising busy.
// Otherwise busy stays high while the reference store streams through the
// cell row (one memory read per cycle), while the last element leaves the
// query's final cell and is caught there, and while the similarity divider
// runs (multiply, setup, up to 16 quotient bits at one per cycle, handoff).
// A score that clamps to zero stops after the first quotient bit.
// The result appears on done_o for exactly one cycle and is not held: the
// receiver must take it in that cycle, there is no back-pressure. A compute
// empties both sequences and clears the overflow mark. Opcode 3 is ignored.
//
// Structure:
//  - Query elements live in the cells themselves, one per cell.
//  - The reference sequence sits in a two-port (write, read) memory, read in
//    order; each element enters cell 0 and moves one cell per cycle.
//  - Cell j keeps column j's running sum; its left neighbor supplies both the
//    left and (from the beat before) the diagonal sum. Idle beats carry an
//    all-ones "no path" sum, and the head feeds zero just before the first
//    element so the corner cell starts from zero.
//  - The distance is tapped at cell m-1 when the last element passes it.
// ----------------------------------------------------------------------------
module dtw_sequence_similarity_unit #(
  parameter int unsigned MAX_LEN = dtw_pkg::MAX_LEN_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [dtw_pkg::OPC_W-1:0]           opcode_i,
  input  logic signed [dtw_pkg::VAL_W-1:0]    element_value_i,
  output logic                                done_o,
  output logic [dtw_pkg::DIST_OUT_W-1:0]      warp_distance_o,
  output logic [dtw_pkg::SIM_W-1:0]           similarity_o,
  output logic                                empty_flag_o,
  output logic                                overflow_flag_o
);

  localparam int unsigned IDX_W = $clog2(MAX_LEN);
  localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);
  // a warping path has fewer than 2*MAX_LEN cells of cost below 2^15,
  // so this leaves the all-ones code free as "no path"
  localparam int unsigned SUM_W = dtw_pkg::VAL_W + 1 + IDX_W;
  localparam int unsigned CMP_W = (SUM_W > dtw_pkg::DIST_OUT_W) ? SUM_W : dtw_pkg::DIST_OUT_W;
  localparam logic [SUM_W-1:0] SUM_INF = {SUM_W{1'b1}};

  // ---------------- control state ----------------
  dtw_pkg::top_state_e state_q, state_d;

  logic [LEN_W-1:0] ref_len_q, qry_len_q;
  logic             drop_q;
  logic [LEN_W-1:0] n_q, m_q;
  logic             ovf_q;
  logic [IDX_W-1:0] rd_idx_q;
  dtw_pkg::cell_ctl_t head_ctl_q;

  logic             accept;
  logic             is_ref, is_qry, is_cmp;
  logic             ref_full, qry_full, seq_empty;
  logic             ref_we, qry_we;
  logic             rd_last;
  logic             issue;
  logic             hit;
  logic             div_start;
  logic             div_done;
  logic [dtw_pkg::SIM_W-1:0] div_sim;

  // ---------------- result beat ----------------
  logic                           done_q;
  logic [dtw_pkg::DIST_OUT_W-1:0] dist_out_q;
  logic [dtw_pkg::SIM_W-1:0]      sim_out_q;
  logic                           empty_out_q;
  logic                           ovf_out_q;

  // ---------------- reference memory ----------------
  logic signed [dtw_pkg::VAL_W-1:0] ref_mem [MAX_LEN];
  logic signed [dtw_pkg::VAL_W-1:0] ref_rd_q;

  // ---------------- cell row links ----------------
  dtw_pkg::cell_ctl_t               ctl_link [MAX_LEN+1];
  logic signed [dtw_pkg::VAL_W-1:0] r_link   [MAX_LEN+1];
  logic        [SUM_W-1:0]          sum_link [MAX_LEN+1];
  logic        [MAX_LEN-1:0]        qwr_en;

  dtw_pkg::cell_ctl_t   tap_ctl;
  logic [SUM_W-1:0]     tap_sum;
  logic [CMP_W-1:0]     tap_ext;
  logic [dtw_pkg::DIST_OUT_W-1:0] dist_sat;

  // ---------------- decode ----------------
  always_comb begin
    is_ref = 1'b0;
    is_qry = 1'b0;
    is_cmp = 1'b0;
    case (dtw_pkg::opcode_e'(opcode_i))
      dtw_pkg::OP_LOAD_REF: is_ref = 1'b1;
      dtw_pkg::OP_LOAD_QRY: is_qry = 1'b1;
      dtw_pkg::OP_COMPUTE:  is_cmp = 1'b1;
      default:              is_cmp = 1'b0;
    endcase
  end

  assign accept    = start && !busy;
  assign ref_full  = (ref_len_q == LEN_W'(MAX_LEN));
  assign qry_full  = (qry_len_q == LEN_W'(MAX_LEN));
  assign seq_empty = (ref_len_q == '0) || (qry_len_q == '0);
  assign ref_we    = accept && is_ref && !ref_full;
  assign qry_we    = accept && is_qry && !qry_full;
  assign rd_last   = (LEN_W'(rd_idx_q) == n_q - LEN_W'(1));

  assign tap_ctl = ctl_link[m_q];
  assign tap_sum = sum_link[m_q];
  assign hit     = tap_ctl.valid && tap_ctl.last;

  assign tap_ext  = CMP_W'(tap_sum);
  assign dist_sat = (tap_ext > CMP_W'(dtw_pkg::DIST_MAX)) ? dtw_pkg::DIST_MAX
                                                          : tap_ext[dtw_pkg::DIST_OUT_W-1:0];

  // ---------------- sequencer: next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      dtw_pkg::TOP_IDLE:   if (accept && is_cmp && !seq_empty) state_d = dtw_pkg::TOP_STREAM;
      dtw_pkg::TOP_STREAM: if (rd_last) state_d = dtw_pkg::TOP_DRAIN;
      dtw_pkg::TOP_DRAIN:  if (hit) state_d = dtw_pkg::TOP_DIV;
      dtw_pkg::TOP_DIV:    if (div_done) state_d = dtw_pkg::TOP_IDLE;
      default:             state_d = dtw_pkg::TOP_IDLE;
    endcase
  end

  // ---------------- sequencer: outputs ----------------
  always_comb begin
    busy      = 1'b1;
    issue     = 1'b0;
    div_start = 1'b0;
    case (state_q)
      dtw_pkg::TOP_IDLE:   busy      = 1'b0;
      dtw_pkg::TOP_STREAM: issue     = 1'b1;
      dtw_pkg::TOP_DRAIN:  div_start = hit;
      dtw_pkg::TOP_DIV:    busy      = 1'b1;
      default:             busy      = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= dtw_pkg::TOP_IDLE;
      ref_len_q  <= '0;
      qry_len_q  <= '0;
      drop_q     <= 1'b0;
      rd_idx_q   <= '0;
      head_ctl_q <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      // empty sequence answers right away; otherwise when the divider is done
      done_q  <= (accept && is_cmp && seq_empty) ||
                 (state_q == dtw_pkg::TOP_DIV && div_done);

      if (ref_we) begin
        ref_len_q <= ref_len_q + LEN_W'(1);
      end
      if (qry_we) begin
        qry_len_q <= qry_len_q + LEN_W'(1);
      end
      if (accept && ((is_ref && ref_full) || (is_qry && qry_full))) begin
        drop_q <= 1'b1;
      end

      if (accept && is_cmp) begin
        ref_len_q <= '0;
        qry_len_q <= '0;
        drop_q    <= 1'b0;
        rd_idx_q  <= '0;
      end

      head_ctl_q.valid <= issue;
      head_ctl_q.first <= issue && (rd_idx_q == '0);
      head_ctl_q.last  <= issue && rd_last;
      if (issue) begin
        rd_idx_q <= rd_idx_q + IDX_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept && is_cmp) begin
      n_q   <= ref_len_q;
      m_q   <= qry_len_q;
      ovf_q <= drop_q;
      if (seq_empty) begin
        dist_out_q  <= dtw_pkg::ONE_Q12;
        sim_out_q   <= '0;
        empty_out_q <= 1'b1;
        ovf_out_q   <= drop_q;
      end
    end
    if (div_start) begin
      dist_out_q <= dist_sat;
    end
    if (state_q == dtw_pkg::TOP_DIV && div_done) begin
      sim_out_q   <= div_sim;
      empty_out_q <= 1'b0;
      ovf_out_q   <= ovf_q;
    end
  end

  // reference store, read in order during streaming
  always_ff @(posedge clk_i) begin
    if (ref_we) begin
      ref_mem[ref_len_q[IDX_W-1:0]] <= element_value_i;
    end
    ref_rd_q <= ref_mem[rd_idx_q];
  end

  // ---------------- cell row ----------------
  assign ctl_link[0] = head_ctl_q;
  assign r_link[0]   = ref_rd_q;
  // zero just ahead of the first element seeds the corner cell's diagonal
  assign sum_link[0] = head_ctl_q.valid ? SUM_INF : '0;

  for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
    assign qwr_en[j] = qry_we && (qry_len_q[IDX_W-1:0] == IDX_W'(j));

    dtw_cell #(
      .SUM_W (SUM_W)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .q_we_i   (qwr_en[j]),
      .q_data_i (element_value_i),
      .ctl_i    (ctl_link[j]),
      .r_i      (r_link[j]),
      .sum_i    (sum_link[j]),
      .ctl_o    (ctl_link[j+1]),
      .r_o      (r_link[j+1]),
      .sum_o    (sum_link[j+1])
    );
  end

  // ---------------- similarity ----------------
  dtw_div #(
    .SUM_W (SUM_W),
    .LEN_W (LEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dist_i  (tap_sum),
    .len_i   (n_q),
    .done_o  (div_done),
    .sim_o   (div_sim)
  );

  assign done_o          = done_q;
  assign warp_distance_o = dist_out_q;
  assign similarity_o    = sim_out_q;
  assign empty_flag_o    = empty_out_q;
  assign overflow_flag_o = ovf_out_q;

endmodule

FILE: tb/tb_dtw_sequence_similarity_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dtw_sequence_similarity_unit: self-checking bench for the DTW unit
// A clocked driver feeds load, compute and ignored beats from a queue with
// random gaps. A clocked monitor runs a cycle-free DTW predictor on every
// accepted beat and compares each done_o strobe, field by field, with the
// oldest predicted score. Directed corner beats come first, then random
// sequence pairs: mostly well formed, plus empty, overfilled and noisy ones.
// ----------------------------------------------------------------------------
module tb_dtw_sequence_similarity_unit;

  localparam int unsigned SEQ_DEPTH   = dtw_pkg::MAX_LEN_DEF;
  localparam int unsigned ITEM_TARGET = 700;
  // Drain after the last score: outlasts the longest compute
  localparam int unsigned POST_DRAIN  = 2 * SEQ_DEPTH + 64;

  // opcode 3 has no package name; the block ignores it
  localparam logic [dtw_pkg::OPC_W-1:0] OP_UNUSED = 2'd3;

  localparam logic [dtw_pkg::VAL_W-1:0] ANGLE_MAX = 15'h3FFF;  // +16383
  localparam logic [dtw_pkg::VAL_W-1:0] ANGLE_MIN = 15'h4000;  // -16384

  // Scoring constants, kept apart from the RTL's own
  localparam longint unsigned                PI_SCALED   = 64'd1686629713;  // pi * 2^29
  localparam logic [dtw_pkg::DIST_OUT_W-1:0] EMPTY_DIST  = 22'd4096;
  localparam logic [dtw_pkg::DIST_OUT_W-1:0] DIST_CAP    = 22'h3FFFFF;
  localparam longint unsigned                FULL_SCORE  = 64'd32768;

  // Value styles for random sequence pairs
  localparam int unsigned STYLE_RANDOM  = 0;
  localparam int unsigned STYLE_CLOSE   = 1;  // small spread, high similarity
  localparam int unsigned STYLE_EXTREME = 2;  // rails only, large distances
  localparam int unsigned STYLE_MIRROR  = 3;  // query copies reference

  typedef struct packed {
    logic [dtw_pkg::OPC_W-1:0] op;
    logic [dtw_pkg::VAL_W-1:0] value;
  } beat_t;

  typedef struct {
    logic [dtw_pkg::DIST_OUT_W-1:0] distance;
    logic [dtw_pkg::SIM_W-1:0]      sim;
    logic                           empty;
    logic                           dropped;
  } score_t;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              start;
  logic                              busy;
  logic [dtw_pkg::OPC_W-1:0]         opcode_i;
  logic signed [dtw_pkg::VAL_W-1:0]  element_value_i;
  logic                              done_o;
  logic [dtw_pkg::DIST_OUT_W-1:0]    warp_distance_o;
  logic [dtw_pkg::SIM_W-1:0]         similarity_o;
  logic                              empty_flag_o;
  logic                              overflow_flag_o;

  dtw_sequence_similarity_unit #(
    .MAX_LEN(SEQ_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .element_value_i(element_value_i),
    .done_o         (done_o),
    .warp_distance_o(warp_distance_o),
    .similarity_o   (similarity_o),
    .empty_flag_o   (empty_flag_o),
    .overflow_flag_o(overflow_flag_o)
  );

  // Stimulus and scoreboard storage
  beat_t  pending_beats[$];
  score_t pending_scores[$];
  int unsigned beats_queued;
  int unsigned counted_beats;   // loads and computes only

  // Predictor state
  logic signed [dtw_pkg::VAL_W-1:0] ref_angles[SEQ_DEPTH];
  logic signed [dtw_pkg::VAL_W-1:0] qry_angles[SEQ_DEPTH];
  int unsigned ref_count;
  int unsigned qry_count;
  logic        load_dropped;

  // Handshake seen at the last rising edge
  logic beat_taken;

  // Run statistics
  int unsigned beats_taken;
  int unsigned ignored_beats;
  int unsigned scores_checked;
  int unsigned empty_scores;
  int unsigned dropped_scores;
  int unsigned zero_scores;
  int unsigned perfect_scores;
  int unsigned mismatch_count;

  // Driver-private pacing
  int unsigned gap_left;
  int unsigned burst_left;

  // --------------------------------------------------------------------------
  // Clock, reset, timeout
  // --------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("%0t ns: timeout, %0d of %0d beats taken, %0d scores outstanding",
             $time, beats_taken, beats_queued, pending_scores.size());
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic int unsigned angle_gap(int unsigned i, int unsigned j);
    int d;
    d = int'(ref_angles[i]) - int'(qry_angles[j]);
    return (d < 0) ? -d : d;
  endfunction

  // DTW with a single row of running sums, column j per query element
  function automatic int unsigned warp_total(int unsigned n, int unsigned m);
    int unsigned row[SEQ_DEPTH];
    int unsigned diag;
    int unsigned up;
    int unsigned best;
    row[0] = angle_gap(0, 0);
    for (int unsigned j = 1; j < m; j++) row[j] = row[j-1] + angle_gap(0, j);
    for (int unsigned i = 1; i < n; i++) begin
      diag   = row[0];
      row[0] = diag + angle_gap(i, 0);
      for (int unsigned j = 1; j < m; j++) begin
        up   = row[j];
        best = (up < row[j-1]) ? up : row[j-1];
        best = (best < diag) ? best : diag;
        row[j] = angle_gap(i, j) + best;
        diag = up;
      end
    end
    return row[m-1];
  endfunction

  function automatic score_t score_pair();
    score_t          s;
    int unsigned     total;
    longint unsigned num;
    longint unsigned den;
    longint unsigned penalty;
    s.empty   = (ref_count == 0) || (qry_count == 0);
    s.dropped = load_dropped;
    if (s.empty) begin
      s.distance = EMPTY_DIST;
      s.sim      = '0;
    end else begin
      total   = warp_total(ref_count, qry_count);
      // similarity = 1 - D / (n * pi) in Q15, rounded half up
      num     = longint'(total) << 32;
      den     = longint'(ref_count) * PI_SCALED;
      penalty = (num + den / 2) / den;
      s.sim   = (penalty >= FULL_SCORE) ? '0 : dtw_pkg::SIM_W'(FULL_SCORE - penalty);
      s.distance = (total > int'(DIST_CAP)) ? DIST_CAP : dtw_pkg::DIST_OUT_W'(total);
    end
    return s;
  endfunction

  // Advance the predictor by one accepted beat
  function automatic void apply_beat(logic [dtw_pkg::OPC_W-1:0] op,
                                     logic [dtw_pkg::VAL_W-1:0] value);
    score_t s;
    case (op)
      dtw_pkg::OP_LOAD_REF: begin
        if (ref_count < SEQ_DEPTH) begin
          ref_angles[ref_count] = value;
          ref_count++;
        end else begin
          load_dropped = 1'b1;
        end
      end
      dtw_pkg::OP_LOAD_QRY: begin
        if (qry_count < SEQ_DEPTH) begin
          qry_angles[qry_count] = value;
          qry_count++;
        end else begin
          load_dropped = 1'b1;
        end
      end
      dtw_pkg::OP_COMPUTE: begin
        s = score_pair();
        pending_scores.insert(pending_scores.size(), s);
        if (s.empty) empty_scores++;
        if (s.dropped) dropped_scores++;
        if (!s.empty && s.sim == '0) zero_scores++;
        if (s.sim == dtw_pkg::SIM_W'(FULL_SCORE)) perfect_scores++;
        // a compute empties both sequences
        ref_count    = 0;
        qry_count    = 0;
        load_dropped = 1'b0;
      end
      default: begin
        ignored_beats++;
      end
    endcase
  endfunction

  function automatic void check_field(string field, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: scores are checked before the beat of the same edge is applied
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_scores
    score_t want;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        scores_checked++;
        if (pending_scores.size() == 0) begin
          $display("%0t ns: unexpected score, expected none, actual dist %0d sim %0d",
                   $time, warp_distance_o, similarity_o);
          mismatch_count++;
        end else begin
          want = pending_scores.pop_front();
          check_field("warp_distance", want.distance, warp_distance_o);
          check_field("similarity", want.sim, similarity_o);
          check_field("empty_flag", want.empty, empty_flag_o);
          check_field("overflow_flag", want.dropped, overflow_flag_o);
        end
      end else if (done_o !== 1'b0) begin
        $display("%0t ns: done_o unknown, expected 0 or 1, actual %b", $time, done_o);
        mismatch_count++;
      end

      if (start && (busy === 1'b0)) begin
        beats_taken++;
        apply_beat(opcode_i, element_value_i);
      end
      beat_taken <= start && (busy === 1'b0);
    end
  end

  // --------------------------------------------------------------------------
  // Driver: a beat holds until taken; gaps are short, sometimes long, with
  // occasional back-to-back bursts
  // --------------------------------------------------------------------------
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  always @(negedge clk_i) begin : drive_beats
    beat_t nxt;
    if (rst_ni) begin
      if (start && !beat_taken) begin
        // still waiting on busy
      end else if (gap_left != 0) begin
        gap_left--;
        start           <= 1'b0;
        opcode_i        <= dtw_pkg::OPC_W'($urandom);
        element_value_i <= dtw_pkg::VAL_W'($urandom);
      end else if (pending_beats.size() != 0) begin
        nxt = pending_beats.pop_front();
        start           <= 1'b1;
        opcode_i        <= nxt.op;
        element_value_i <= nxt.value;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          gap_left = draw_gap();
          if ($urandom_range(0, 99) < 5) burst_left = $urandom_range(8, 40);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic void queue_beat(logic [dtw_pkg::OPC_W-1:0] op,
                                     logic [dtw_pkg::VAL_W-1:0] value);
    beat_t b;
    b.op    = op;
    b.value = value;
    pending_beats.insert(pending_beats.size(), b);
    if (op != OP_UNUSED) counted_beats++;
  endfunction

  function automatic logic [dtw_pkg::VAL_W-1:0] draw_angle(int unsigned style, int base);
    case (style)
      STYLE_CLOSE:   return dtw_pkg::VAL_W'(base + int'($urandom_range(0, 400)) - 200);
      STYLE_EXTREME: return $urandom_range(0, 1) ? ANGLE_MAX : ANGLE_MIN;
      default:       return dtw_pkg::VAL_W'($urandom);
    endcase
  endfunction

  // Mostly short sequences; a few run past the store depth
  function automatic int unsigned draw_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return 0;
    else if (r < 86) return $urandom_range(1, 8);
    else if (r < 96) return $urandom_range(9, 32);
    else return $urandom_range(SEQ_DEPTH - 8, SEQ_DEPTH + 6);
  endfunction

  // Interleaved loads of both sequences, sprinkled with ignored beats, then
  // the compute beat
  function automatic void queue_pair(int unsigned n, int unsigned m, int unsigned style);
    logic [dtw_pkg::VAL_W-1:0] ref_vals[$];
    logic [dtw_pkg::VAL_W-1:0] qry_vals[$];
    int base;
    base = int'($urandom_range(0, 24000)) - 12000;
    for (int unsigned i = 0; i < n; i++)
      ref_vals.insert(ref_vals.size(), draw_angle(style, base));
    if (style == STYLE_MIRROR) qry_vals = ref_vals;
    else for (int unsigned j = 0; j < m; j++)
      qry_vals.insert(qry_vals.size(), draw_angle(style, base));
    while (ref_vals.size() != 0 || qry_vals.size() != 0) begin
      if ($urandom_range(0, 99) < 3) queue_beat(OP_UNUSED, dtw_pkg::VAL_W'($urandom));
      if (qry_vals.size() == 0 || (ref_vals.size() != 0 && $urandom_range(0, 1)))
        queue_beat(dtw_pkg::OP_LOAD_REF, ref_vals.pop_front());
      else
        queue_beat(dtw_pkg::OP_LOAD_QRY, qry_vals.pop_front());
    end
    queue_beat(dtw_pkg::OP_COMPUTE, dtw_pkg::VAL_W'($urandom));
  endfunction

  initial begin : run_test
    int unsigned style;
    int unsigned n;
    int unsigned m;

    start           = 1'b0;
    opcode_i        = dtw_pkg::OP_LOAD_REF;
    element_value_i = '0;
    rst_ni          = 1'b0;
    beat_taken      = 1'b0;
    ref_count       = 0;
    qry_count       = 0;
    load_dropped    = 1'b0;
    gap_left        = 0;
    burst_left      = 0;
    counted_beats   = 0;
    beats_taken     = 0;
    ignored_beats   = 0;
    scores_checked  = 0;
    empty_scores    = 0;
    dropped_scores  = 0;
    zero_scores     = 0;
    perfect_scores  = 0;
    mismatch_count  = 0;

    // Directed: empty sequences on either side and both
    queue_beat(dtw_pkg::OP_COMPUTE, ANGLE_MAX);
    queue_beat(dtw_pkg::OP_LOAD_REF, ANGLE_MAX);
    queue_beat(dtw_pkg::OP_COMPUTE, '0);
    queue_beat(dtw_pkg::OP_LOAD_QRY, ANGLE_MIN);
    queue_beat(dtw_pkg::OP_COMPUTE, '0);
    // widest single cost, similarity clamps to zero
    queue_beat(dtw_pkg::OP_LOAD_REF, ANGLE_MAX);
    queue_beat(dtw_pkg::OP_LOAD_QRY, ANGLE_MIN);
    queue_beat(dtw_pkg::OP_COMPUTE, ANGLE_MIN);
    // exact match with an ignored opcode in between
    queue_beat(dtw_pkg::OP_LOAD_REF, '0);
    queue_beat(OP_UNUSED, 15'h7FFF);
    queue_beat(dtw_pkg::OP_LOAD_QRY, '0);
    queue_beat(dtw_pkg::OP_COMPUTE, '0);
    // rails crossed in a 2x2
    queue_beat(dtw_pkg::OP_LOAD_REF, ANGLE_MIN);
    queue_beat(dtw_pkg::OP_LOAD_REF, ANGLE_MAX);
    queue_beat(dtw_pkg::OP_LOAD_QRY, ANGLE_MAX);
    queue_beat(dtw_pkg::OP_LOAD_QRY, ANGLE_MIN);
    queue_beat(dtw_pkg::OP_COMPUTE, '0);
    // small uneven pair, mixed signs
    queue_beat(dtw_pkg::OP_LOAD_REF, dtw_pkg::VAL_W'(100));
    queue_beat(dtw_pkg::OP_LOAD_REF, dtw_pkg::VAL_W'(200));
    queue_beat(dtw_pkg::OP_LOAD_REF, dtw_pkg::VAL_W'(-300));
    queue_beat(dtw_pkg::OP_LOAD_QRY, dtw_pkg::VAL_W'(150));
    queue_beat(dtw_pkg::OP_LOAD_QRY, dtw_pkg::VAL_W'(-250));
    queue_beat(dtw_pkg::OP_COMPUTE, '0);

    // Full stores: overfill each side once, then the largest distance
    queue_pair(SEQ_DEPTH + 3, 5, STYLE_RANDOM);
    queue_pair(4, SEQ_DEPTH + 2, STYLE_CLOSE);
    queue_pair(SEQ_DEPTH, SEQ_DEPTH, STYLE_EXTREME);

    while (counted_beats < ITEM_TARGET) begin
      style = $urandom_range(STYLE_RANDOM, STYLE_MIRROR);
      n     = draw_length();
      m     = (style == STYLE_MIRROR) ? n : draw_length();
      queue_pair(n, m, style);
    end
    beats_queued = pending_beats.size();

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (beats_taken < beats_queued || pending_scores.size() != 0);
    // stray strobes after the last score still count as failures
    repeat (POST_DRAIN) @(negedge clk_i);

    $display("Covered %0d beats (%0d ignored opcodes) and checked %0d scores.",
             beats_taken, ignored_beats, scores_checked);
    $display("Scores: %0d empty, %0d with dropped loads, %0d clamped to 0, %0d perfect.",
             empty_scores, dropped_scores, zero_scores, perfect_scores);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
